### hw/rtl/gco_pkg.sv
// ----------------------------------------------------------------------------
// gco_pkg: shared constants for the grid cell openness core
// Field widths, register indexes and parameter defaults used by more than
// one file of the block.
// ----------------------------------------------------------------------------
package gco_pkg;

    // Field widths fixed by the interface.
    localparam int CORD_W     = 8;
    localparam int OUT_W      = 5;
    localparam int MAXOPEN_W  = 5;
    localparam int DIM_CFG_W  = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Parameter defaults.
    localparam int DEF_MAX_DIM      = 256;
    localparam int DEF_MAX_OPENNESS = 31;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_OPENNESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT  = 2'd2;

endpackage

### hw/rtl/gco_bitmap.sv
// ----------------------------------------------------------------------------
// gco_bitmap: solid-cell bitmap memory
// One row of cells per word, single-bit writes, one registered row read.
// After reset a sweep sets every row to all solid, one row per cycle.
// ----------------------------------------------------------------------------
module gco_bitmap #(
    parameter int MAX_DIM = gco_pkg::DEF_MAX_DIM,
    parameter int AW      = $clog2(MAX_DIM)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_rd_row,
    output logic [MAX_DIM-1:0] o_rd_data,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_row,
    input  logic [AW-1:0]      i_wr_col,
    input  logic               i_wr_val,
    output logic               o_clearing
);
    import gco_pkg::*;

    logic [MAX_DIM-1:0] mem [MAX_DIM];
    logic [MAX_DIM-1:0] r_rd_data;
    logic               r_clearing;
    logic [AW-1:0]      r_clr_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clearing) begin
            r_clr_row <= r_clr_row + 1'b1;
            if (r_clr_row == AW'(MAX_DIM - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_row] <= '1;
        end else if (i_wr_en) begin
            mem[i_wr_row][i_wr_col] <= i_wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_row];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

### hw/rtl/gco_row_window.sv
// ----------------------------------------------------------------------------
// gco_row_window: cut the ring window out of one bitmap row
// Gives the solid flags of the columns around the centre column; cells out
// of the grid, and every cell of a row out of the grid, read as solid.
// ----------------------------------------------------------------------------
module gco_row_window #(
    parameter int MAX_DIM = gco_pkg::DEF_MAX_DIM,
    parameter int AW      = $clog2(MAX_DIM),
    parameter int DW      = $clog2(MAX_DIM + 1),
    parameter int WIN_R   = 15,
    parameter int SW      = 10
) (
    input  logic [MAX_DIM-1:0]        i_row,
    input  logic                      i_row_ok,
    input  logic [gco_pkg::CORD_W-1:0] i_cx,
    input  logic [DW-1:0]             i_width,
    output logic [2*WIN_R:0]          o_win
);
    import gco_pkg::*;

    localparam int CW = ((SW - 1) > DW) ? (SW - 1) : DW;

    for (genvar j = 0; j <= 2 * WIN_R; j++) begin : g_col
        localparam int OFS = j - WIN_R;
        logic signed [SW-1:0] x;
        logic [CW-1:0]        xu;
        logic [CW-1:0]        wu;

        assign x  = $signed({{(SW - CORD_W){1'b0}}, i_cx}) + SW'(OFS);
        assign xu = CW'(x[SW-2:0]);
        assign wu = CW'(i_width);
        assign o_win[j] = !i_row_ok || x[SW-1] || (xu >= wu) || i_row[x[AW-1:0]];
    end

endmodule

### hw/rtl/grid_cell_openness_core.sv
// ----------------------------------------------------------------------------
// grid_cell_openness_core: solid-cell bitmap with an openness query
// Stores one wall bit per grid cell and answers, for a queried cell, how far
// the free space around it reaches in square rings.
// ----------------------------------------------------------------------------
// A write beat gives no result. A query strobes its result in the first cycle
// with busy low again; with zero max_openness busy stays low, else it reads
// the centre row, then the top and bottom rows of each ring until decided.
// Throughput is one beat at a time, set by the single read port of the
// bitmap memory: each ring needs two row reads. Reset: a sweep sets every
// cell solid with busy high; the receiver cannot stall.
// ----------------------------------------------------------------------------
module grid_cell_openness_core #(
    parameter int MAX_DIM      = gco_pkg::DEF_MAX_DIM,
    parameter int MAX_OPENNESS = gco_pkg::DEF_MAX_OPENNESS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Command channel.
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_func,
    input  logic [gco_pkg::CORD_W-1:0]     i_cell_x,
    input  logic [gco_pkg::CORD_W-1:0]     i_cell_y,
    input  logic                           i_wall_present,
    // Result channel.
    output logic                           o_valid,
    output logic [gco_pkg::OUT_W-1:0]      o_openness,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic [gco_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gco_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gco_pkg::*;

    // Address width of the bitmap and width of a clamped grid dimension.
    localparam int AW    = $clog2(MAX_DIM);
    localparam int DW    = $clog2(MAX_DIM + 1);
    // Largest ring radius ever walked, and the window radius built for it.
    localparam int KR    = (MAX_OPENNESS + 1) / 2 - 1;
    localparam int WIN_R = (KR < 1) ? 1 : KR;
    localparam int WW    = 2 * WIN_R + 1;
    // Ring counter holds values up to the ring count.
    localparam int RW    = $clog2((MAX_OPENNESS + 1) / 2 + 1);
    localparam int OW    = RW + 1;
    // Signed row and column coordinates around the centre.
    localparam int SW0   = (AW > CORD_W) ? AW : CORD_W;
    localparam int SW    = ((RW > SW0) ? RW : SW0) + 2;
    localparam int CW    = ((SW - 1) > DW) ? (SW - 1) : DW;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,   // waiting for a beat
        S_CTR  = 4'b0010,   // centre row data is back
        S_BOT  = 4'b0100,   // top row of the ring is back
        S_EVAL = 4'b1000    // bottom row of the ring is back, judge the ring
    } t_state;

    // Configuration registers.
    logic [MAXOPEN_W-1:0] r_max_open;
    logic [DIM_CFG_W-1:0] r_grid_w;
    logic [DIM_CFG_W-1:0] r_grid_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_open <= '0;
            r_grid_w   <= DIM_CFG_W'(256);
            r_grid_h   <= DIM_CFG_W'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_OPENNESS: r_max_open <= i_cfg_data[MAXOPEN_W-1:0];
                CFG_GRID_WIDTH:   r_grid_w   <= i_cfg_data[DIM_CFG_W-1:0];
                CFG_GRID_HEIGHT:  r_grid_h   <= i_cfg_data[DIM_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Grid size clamped to the bitmap, and the ring count of a query.
    logic [DW-1:0]        w_eff;
    logic [DW-1:0]        h_eff;
    logic [MAXOPEN_W-1:0] m_eff;
    logic [RW-1:0]        rings;

    assign w_eff = (r_grid_w > MAX_DIM) ? DW'(MAX_DIM) : DW'(r_grid_w);
    assign h_eff = (r_grid_h > MAX_DIM) ? DW'(MAX_DIM) : DW'(r_grid_h);
    assign m_eff = (r_max_open > MAX_OPENNESS) ? MAXOPEN_W'(MAX_OPENNESS) : r_max_open;
    assign rings = RW'(({1'b0, m_eff} + 1'b1) >> 1);

    // A row lies in the grid when its signed coordinate is in [0, height).
    function automatic logic row_in_grid(input logic signed [SW-1:0] ry,
                                         input logic [DW-1:0] hgt);
        logic [CW-1:0] yu;
        logic [CW-1:0] hu;
        yu = CW'(ry[SW-2:0]);
        hu = CW'(hgt);
        return !ry[SW-1] && (yu < hu);
    endfunction

    // Control state of the query walk.
    t_state               r_state, n_state;
    logic [CORD_W-1:0]    r_cx, n_cx;
    logic [CORD_W-1:0]    r_cy, n_cy;
    logic [RW-1:0]        r_rings, n_rings;
    logic [RW-1:0]        r_r, n_r;
    logic                 r_row_ok, n_row_ok;
    logic [WW-1:0]        r_top, n_top;
    logic [WW-1:0]        r_col, n_col;
    logic                 r_valid, n_valid;
    logic [OUT_W-1:0]     r_open, n_open;

    // Bitmap ports.
    logic                 rd_en;
    logic [AW-1:0]        rd_row;
    logic [MAX_DIM-1:0]   rd_data;
    logic                 wr_en;
    logic                 clearing;

    // Window of the row that came back from memory this cycle.
    logic [WW-1:0]        win;

    gco_bitmap #(
        .MAX_DIM (MAX_DIM),
        .AW      (AW)
    ) u_bitmap (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_row   (rd_row),
        .o_rd_data  (rd_data),
        .i_wr_en    (wr_en),
        .i_wr_row   (AW'(i_cell_y)),
        .i_wr_col   (AW'(i_cell_x)),
        .i_wr_val   (i_wall_present),
        .o_clearing (clearing)
    );

    gco_row_window #(
        .MAX_DIM (MAX_DIM),
        .AW      (AW),
        .DW      (DW),
        .WIN_R   (WIN_R),
        .SW      (SW)
    ) u_row_window (
        .i_row    (rd_data),
        .i_row_ok (r_row_ok),
        .i_cx     (r_cx),
        .i_width  (w_eff),
        .o_win    (win)
    );

    logic accept;
    assign busy   = clearing || (r_state != S_IDLE);
    assign accept = start && !busy;

    // A write to a cell beyond the bitmap is dropped.
    assign wr_en = accept && !i_func && (i_cell_x < MAX_DIM) && (i_cell_y < MAX_DIM);

    // Ring judgement. The inner mask covers the edge cells of the ring without
    // its corners; the left and right masks pick the ring's corner columns.
    // r_col holds the OR of all rows strictly inside the ring, so its bits at
    // the corner columns tell whether the ring's left or right side is solid.
    logic [WW-1:0] inner_m, left_m, right_m;
    logic          s_top, s_bot, s_left, s_right;
    logic          c_tl, c_tr, c_bl, c_br;
    logic          ring_solid, ring_ext;
    logic [OW-1:0] ring_val;
    logic [OW-1:0] full_val;

    always_comb begin
        for (int j = 0; j < WW; j++) begin
            inner_m[j] = (j + int'(r_r) > WIN_R) && (j < WIN_R + int'(r_r));
            left_m[j]  = (j + int'(r_r) == WIN_R);
            right_m[j] = (j == WIN_R + int'(r_r));
        end
    end

    assign s_top   = |(r_top & inner_m);
    assign s_bot   = |(win & inner_m);
    assign s_left  = |(r_col & left_m);
    assign s_right = |(r_col & right_m);
    assign c_tl    = |(r_top & left_m);
    assign c_tr    = |(r_top & right_m);
    assign c_bl    = |(win & left_m);
    assign c_br    = |(win & right_m);

    assign ring_solid = s_top || s_bot || s_left || s_right || c_tl || c_tr || c_bl || c_br;
    assign ring_ext   = (!c_tl && !s_top && !s_left) || (!c_tr && !s_top && !s_right) ||
                        (!c_bl && !s_bot && !s_left) || (!c_br && !s_bot && !s_right);
    assign ring_val   = OW'({r_r, 1'b0}) - OW'(1) + OW'(ring_ext);
    assign full_val   = OW'({r_rings, 1'b0}) - OW'(1);

    // Next row coordinates for each read the walk issues.
    logic signed [SW-1:0] cy_s;
    logic signed [SW-1:0] ry_up;
    logic signed [SW-1:0] ry_dn;
    logic signed [SW-1:0] ry_next;
    logic [RW-1:0]        r_inc;

    assign r_inc   = r_r + 1'b1;
    assign cy_s    = $signed({{(SW - CORD_W){1'b0}}, r_cy});
    assign ry_up   = cy_s - $signed(SW'(r_r));
    assign ry_dn   = cy_s + $signed(SW'(r_r));
    assign ry_next = cy_s - $signed(SW'(r_inc));

    always_comb begin
        n_state  = r_state;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_rings  = r_rings;
        n_r      = r_r;
        n_row_ok = r_row_ok;
        n_top    = r_top;
        n_col    = r_col;
        n_valid  = 1'b0;
        n_open   = r_open;
        rd_en    = 1'b0;
        rd_row   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept && i_func) begin
                    if (m_eff == '0) begin
                        n_valid = 1'b1;
                        n_open  = '0;
                    end else begin
                        // Read the centre row.
                        n_cx     = i_cell_x;
                        n_cy     = i_cell_y;
                        n_rings  = rings;
                        n_r      = RW'(1);
                        n_row_ok = row_in_grid($signed({{(SW - CORD_W){1'b0}}, i_cell_y}),
                                               h_eff);
                        rd_en    = n_row_ok;
                        rd_row   = AW'(i_cell_y);
                        n_state  = S_CTR;
                    end
                end
            end
            S_CTR: begin
                if (win[WIN_R]) begin
                    // Solid centre.
                    n_valid = 1'b1;
                    n_open  = '0;
                    n_state = S_IDLE;
                end else if (r_rings == RW'(1)) begin
                    n_valid = 1'b1;
                    n_open  = OUT_W'(full_val);
                    n_state = S_IDLE;
                end else begin
                    n_col    = win;
                    n_row_ok = row_in_grid(ry_up, h_eff);
                    rd_en    = n_row_ok;
                    rd_row   = ry_up[AW-1:0];
                    n_state  = S_BOT;
                end
            end
            S_BOT: begin
                n_top    = win;
                n_row_ok = row_in_grid(ry_dn, h_eff);
                rd_en    = n_row_ok;
                rd_row   = ry_dn[AW-1:0];
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                if (ring_solid) begin
                    n_valid = 1'b1;
                    n_open  = OUT_W'(ring_val);
                    n_state = S_IDLE;
                end else if (r_inc == r_rings) begin
                    n_valid = 1'b1;
                    n_open  = OUT_W'(full_val);
                    n_state = S_IDLE;
                end else begin
                    // Ring is clear: fold its rows into the column summary and
                    // start on the next ring's top row.
                    n_col    = r_col | r_top | win;
                    n_r      = r_inc;
                    n_row_ok = row_in_grid(ry_next, h_eff);
                    rd_en    = n_row_ok;
                    rd_row   = ry_next[AW-1:0];
                    n_state  = S_BOT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_row_ok <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_row_ok <= n_row_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_rings <= n_rings;
        r_r     <= n_r;
        r_top   <= n_top;
        r_col   <= n_col;
        r_open  <= n_open;
    end

    assign o_valid    = r_valid;
    assign o_openness = r_open;

endmodule
